@@ sv/kbme_pkg.sv @@
// ----------------------------------------------------------------------------
// kbme_pkg
// Shared types and constants for the keyed byte MAC engine.
// ----------------------------------------------------------------------------
package kbme_pkg;

  localparam logic [1:0] OP_KEY    = 2'd0;
  localparam logic [1:0] OP_DATA   = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // queued transaction between front and back
  typedef struct packed {
    logic [1:0] op;
    logic [7:0] byte_value;
  } kbme_item_t;

  // back-end sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_KEY,
    ST_SCH_RD0,
    ST_SCH_RD1,
    ST_SCH_WR,
    ST_MIX_RD0,
    ST_MIX_RD1,
    ST_MIX_WR,
    ST_EMIT
  } kbme_state_t;

endpackage

@@ sv/kbme_front.sv @@
// ----------------------------------------------------------------------------
// kbme_front
// Accepts input transactions, drops unused codes and queues the rest.
// ----------------------------------------------------------------------------
module kbme_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_op,
  input  logic [7:0]          in_byte_value,
  output logic                q_valid,
  input  logic                q_ready,
  output kbme_pkg::kbme_item_t q_item
);

  kbme_pkg::kbme_item_t mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign in_ready = (cnt_r != 2'd2);
  // unused op code is accepted and discarded
  assign push     = in_valid && in_ready && (in_op != kbme_pkg::OP_UNUSED);
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_item   = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  // two-entry queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      mem_r[wp_r] <= '{op: in_op, byte_value: in_byte_value};
    end
  end

endmodule

@@ sv/kbme_back.sv @@
// ----------------------------------------------------------------------------
// kbme_back
// Sequencer that runs table clear, key load, key schedule, mixing rounds and
// tag output over a single-port mixing table memory.
// ----------------------------------------------------------------------------
module kbme_back #(
  parameter int TAG_BYTES    = 16,
  parameter int FINAL_PASSES = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  kbme_pkg::kbme_item_t q_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_mac_byte,
  output logic                 out_final_byte
);

  localparam int TW = (TAG_BYTES > 1) ? $clog2(TAG_BYTES) : 1;
  localparam int FR = TAG_BYTES * FINAL_PASSES;
  localparam int FW = $clog2(FR + 1);

  kbme_pkg::kbme_state_t state_r, state_nxt;

  logic [7:0]  mem [256];
  logic [7:0]  rd_r;
  logic [7:0]  mem_addr;
  logic        mem_we;
  logic [7:0]  mem_wd;

  logic [7:0]  tag_r [TAG_BYTES];
  logic [7:0]  sum_r, sum_nxt;
  logic [TW-1:0] tpos_r, tpos_nxt;
  logic [7:0]  tbl_r, tbl_nxt;
  logic [8:0]  kcnt_r, kcnt_nxt;
  logic        done_r, done_nxt;
  logic [1:0]  op_r, op_nxt;
  logic [7:0]  b_r, b_nxt;
  logic [1:0]  pass_r, pass_nxt;
  logic [8:0]  n_r, n_nxt;
  logic [7:0]  a_r, a_nxt;
  logic [FW-1:0] rnd_r, rnd_nxt;
  logic [TW-1:0] p_r, p_nxt;
  logic [7:0]  clr_r, clr_nxt;

  logic [8:0]  d_len;
  logic [7:0]  nb;
  logic [8:0]  nx1;
  logic [7:0]  src1, dst;
  logic [7:0]  newv, e_t, ks;
  logic        tag_we, tag_clr;
  logic [TW-1:0] tag_idx;
  logic [7:0]  tag_wd;

  assign nb    = n_r[7:0];
  assign d_len = 9'd256 - kcnt_r;
  assign nx1   = n_r + 9'd1;
  assign newv  = a_r + rd_r + sum_r;
  assign e_t   = sum_r + newv + ((pass_r == 2'd3) ?
                 (op_r == kbme_pkg::OP_DATA ? 8'(tpos_r) : tbl_r) : nb);
  assign ks    = (e_t + newv) ^ newv;

  // schedule and mixing pass addresses
  always_comb begin
    unique case (pass_r)
      2'd0:    begin src1 = nb + 8'd1; dst = nb; end
      2'd1:    begin
        src1 = (nx1 == d_len) ? 8'd0 : nx1[7:0];
        dst  = nb + kcnt_r[7:0];
      end
      2'd2:    begin src1 = nb + 8'd128; dst = nb; end
      default: begin src1 = tbl_r + 8'd1; dst = tbl_r; end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      kbme_pkg::ST_CLEAR: if (clr_r == 8'hff) state_nxt = kbme_pkg::ST_IDLE;
      kbme_pkg::ST_IDLE: begin
        if (q_valid) begin
          if (q_item.op == kbme_pkg::OP_KEY) state_nxt = kbme_pkg::ST_KEY;
          else if (!done_r) state_nxt = kbme_pkg::ST_SCH_RD0;
          else state_nxt = kbme_pkg::ST_MIX_RD0;
        end
      end
      kbme_pkg::ST_KEY:     state_nxt = kbme_pkg::ST_IDLE;
      kbme_pkg::ST_SCH_RD0: begin
        if (pass_r == 2'd1 && d_len == 9'd0) state_nxt = kbme_pkg::ST_SCH_RD0;
        else state_nxt = kbme_pkg::ST_SCH_RD1;
      end
      kbme_pkg::ST_SCH_RD1: state_nxt = kbme_pkg::ST_SCH_WR;
      kbme_pkg::ST_SCH_WR: begin
        if (pass_r == 2'd2 && n_r == 9'd255) state_nxt = kbme_pkg::ST_MIX_RD0;
        else state_nxt = kbme_pkg::ST_SCH_RD0;
      end
      kbme_pkg::ST_MIX_RD0: state_nxt = kbme_pkg::ST_MIX_RD1;
      kbme_pkg::ST_MIX_RD1: state_nxt = kbme_pkg::ST_MIX_WR;
      kbme_pkg::ST_MIX_WR: begin
        if (op_r == kbme_pkg::OP_DATA) state_nxt = kbme_pkg::ST_IDLE;
        else if (rnd_r == FW'(FR - 1)) state_nxt = kbme_pkg::ST_EMIT;
        else state_nxt = kbme_pkg::ST_MIX_RD0;
      end
      kbme_pkg::ST_EMIT: begin
        if (out_ready && p_r == TW'(TAG_BYTES - 1)) state_nxt = kbme_pkg::ST_CLEAR;
      end
      default: state_nxt = kbme_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    sum_nxt = sum_r; tpos_nxt = tpos_r; tbl_nxt = tbl_r; kcnt_nxt = kcnt_r;
    done_nxt = done_r; op_nxt = op_r; b_nxt = b_r; pass_nxt = pass_r;
    n_nxt = n_r; a_nxt = a_r; rnd_nxt = rnd_r; p_nxt = p_r; clr_nxt = clr_r;
    mem_addr = dst; mem_we = 1'b0; mem_wd = newv;
    tag_we = 1'b0; tag_clr = 1'b0; tag_idx = tpos_r; tag_wd = 8'd0;
    q_ready = 1'b0; out_valid = 1'b0;
    out_mac_byte = tag_r[p_r];
    out_final_byte = (p_r == TW'(TAG_BYTES - 1));
    unique case (state_r)
      kbme_pkg::ST_CLEAR: begin
        mem_addr = clr_r; mem_we = 1'b1; mem_wd = 8'd0;
        clr_nxt = clr_r + 8'd1;
      end
      kbme_pkg::ST_IDLE: begin
        q_ready = 1'b1;
        op_nxt = q_item.op; b_nxt = q_item.byte_value;
        if (q_valid && q_item.op != kbme_pkg::OP_KEY) begin
          n_nxt = 9'd0;
          pass_nxt = done_r ? 2'd3 : 2'd0;
          if (q_item.op == kbme_pkg::OP_FINISH) begin
            tbl_nxt = 8'd0; rnd_nxt = '0; p_nxt = '0;
          end
        end
      end
      kbme_pkg::ST_KEY: begin
        if (!done_r && !kcnt_r[8]) begin
          mem_addr = kcnt_r[7:0]; mem_we = 1'b1; mem_wd = b_r;
          sum_nxt = sum_r + b_r;
          kcnt_nxt = kcnt_r + 9'd1;
        end
      end
      kbme_pkg::ST_SCH_RD0: begin
        if (pass_r == 2'd1 && d_len == 9'd0) begin
          pass_nxt = 2'd2;
        end else begin
          mem_addr = (pass_r == 2'd1) ? nb : dst;
        end
      end
      kbme_pkg::ST_SCH_RD1: begin
        mem_addr = src1; a_nxt = rd_r;
      end
      kbme_pkg::ST_SCH_WR: begin
        mem_addr = dst; mem_we = 1'b1; mem_wd = newv;
        // sum steps by the entry at n, which can differ from dst in pass 1
        if (pass_r == 2'd1 && dst != nb) sum_nxt = sum_r + a_r + nb;
        else sum_nxt = sum_r + newv + nb;
        n_nxt = nx1;
        if ((pass_r == 2'd1 && nx1 == d_len) || (pass_r != 2'd1 && n_r == 9'd255)) begin
          n_nxt = 9'd0;
          if (pass_r == 2'd2) begin
            pass_nxt = 2'd3; done_nxt = 1'b1;
          end else begin
            pass_nxt = pass_r + 2'd1;
          end
        end
      end
      kbme_pkg::ST_MIX_RD0: mem_addr = tbl_r;
      kbme_pkg::ST_MIX_RD1: begin mem_addr = src1; a_nxt = rd_r; end
      kbme_pkg::ST_MIX_WR: begin
        mem_addr = tbl_r; mem_we = 1'b1; mem_wd = newv;
        sum_nxt = e_t;
        tbl_nxt = tbl_r + 8'd1;
        tag_we = 1'b1;
        if (op_r == kbme_pkg::OP_DATA) begin
          tag_idx = tpos_r;
          tag_wd = (tag_r[tpos_r] + b_r) ^ (ks ^ b_r);
          tpos_nxt = (tpos_r == TW'(TAG_BYTES - 1)) ? '0 : tpos_r + 1'b1;
        end else begin
          tag_idx = p_r;
          tag_wd = tag_r[p_r] ^ ks;
          p_nxt = (p_r == TW'(TAG_BYTES - 1)) ? '0 : p_r + 1'b1;
          rnd_nxt = rnd_r + 1'b1;
        end
      end
      kbme_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          p_nxt = p_r + 1'b1;
          if (p_r == TW'(TAG_BYTES - 1)) begin
            tag_clr = 1'b1; sum_nxt = 8'd0; tpos_nxt = '0; tbl_nxt = 8'd0;
            kcnt_nxt = 9'd0; done_nxt = 1'b0; clr_nxt = 8'd0;
          end
        end
      end
      default: ;
    endcase
  end

  // mixing table memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wd;
    rd_r <= mem[mem_addr];
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kbme_pkg::ST_CLEAR;
      sum_r <= 8'd0; tpos_r <= '0; tbl_r <= 8'd0; kcnt_r <= 9'd0;
      done_r <= 1'b0; clr_r <= 8'd0; p_r <= '0;
      rnd_r <= '0; pass_r <= 2'd0; n_r <= 9'd0;
    end else begin
      state_r <= state_nxt;
      sum_r <= sum_nxt; tpos_r <= tpos_nxt; tbl_r <= tbl_nxt; kcnt_r <= kcnt_nxt;
      done_r <= done_nxt; clr_r <= clr_nxt;
      p_r <= p_nxt; rnd_r <= rnd_nxt; pass_r <= pass_nxt; n_r <= n_nxt;
    end
    op_r <= op_nxt; b_r <= b_nxt; a_r <= a_nxt;
  end

  // tag store
  always_ff @(posedge clk) begin
    for (int i = 0; i < TAG_BYTES; i++) begin
      if (!rst_n || tag_clr) tag_r[i] <= 8'd0;
      else if (tag_we && tag_idx == TW'(i)) tag_r[i] <= tag_wd;
    end
  end

endmodule

@@ sv/keyed_byte_mac_engine.sv @@
// Key byte: state KEY. Data byte: MIX_RD0, MIX_RD1, MIX_WR. The first data
// or finish adds a key schedule of SCH_RD0, SCH_RD1, SCH_WR per table step,
// at most 768 steps. Finish: MIX_RD0, MIX_RD1, MIX_WR per final round
// (TAG_BYTES * FINAL_PASSES), then one tag byte per cycle while out_ready is
// high, then a table clear. The queue is served only in IDLE, one item at a
// time. Reset runs the same clear; the two-entry queue may fill meanwhile.
// ----------------------------------------------------------------------------
// keyed_byte_mac_engine
// Keyed byte MAC: front queue plus back-end sequencer over a mixing table.
// ----------------------------------------------------------------------------
module keyed_byte_mac_engine #(
  parameter int TAG_BYTES    = 16,
  parameter int FINAL_PASSES = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_op,
  input  logic [7:0] in_byte_value,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_mac_byte,
  output logic       out_final_byte
);

  logic                 q_valid, q_ready;
  kbme_pkg::kbme_item_t q_item;

  kbme_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_op, .in_byte_value,
    .q_valid, .q_ready, .q_item
  );

  kbme_back #(.TAG_BYTES(TAG_BYTES), .FINAL_PASSES(FINAL_PASSES)) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_item,
    .out_valid, .out_ready, .out_mac_byte, .out_final_byte
  );

endmodule

@@ tb/sv/keyed_byte_mac_engine_tb.sv @@
// ----------------------------------------------------------------------------
// keyed_byte_mac_engine_tb
// Drives key, data, finish and unused-op transactions into the keyed byte MAC engine,
// predicts every tag byte with an independent model of the mixing table and
// compares each emitted byte against the oldest predicted one.
// ----------------------------------------------------------------------------
module keyed_byte_mac_engine_tb;

  localparam int TAGN      = 16;
  localparam int ROUNDS    = TAGN * 2;
  localparam int IDLE_LIM  = 40000;

  typedef struct packed {
    logic [7:0] mac;
    logic       last;
  } tag_beat_t;

  // --------------------------------------------------------------------------
  // Scoreboard: MAC predictor plus queue of expected tag bytes
  // --------------------------------------------------------------------------
  class mac_scoreboard;
    bit [7:0]  tbl [256];
    bit [7:0]  acc;
    bit [7:0]  tag [TAGN];
    int        tpos;
    bit [7:0]  wpos;
    int        nkey;
    bit        sched;
    tag_beat_t pending [$];
    int        errors;

    function void clear();
      foreach (tbl[i]) tbl[i] = 0;
      foreach (tag[i]) tag[i] = 0;
      acc = 0; tpos = 0; wpos = 0; nkey = 0; sched = 0;
    endfunction

    function void key_schedule();
      bit [7:0] t;
      int d;
      t = acc;
      for (int n = 0; n < 256; n++) begin
        tbl[n] = tbl[n] + tbl[(n + 1) & 255] + t;
        t = t + tbl[n] + n[7:0];
      end
      d = 256 - nkey;
      for (int n = 0; n < d; n++) begin
        tbl[(n + nkey) & 255] = tbl[n] + tbl[(n + 1) % d] + t;
        t = t + tbl[n] + n[7:0];
      end
      for (int n = 0; n < 256; n++) begin
        tbl[n] = tbl[n] + tbl[(n + 128) & 255] + t;
        t = t + tbl[n] + n[7:0];
      end
      acc = t;
      sched = 1;
    endfunction

    function bit [7:0] stir(bit [7:0] step);
      bit [7:0] e;
      tbl[wpos] = tbl[wpos] + tbl[wpos + 8'd1] + acc;
      e = tbl[wpos];
      acc = acc + e + step;
      return (acc + e) ^ e;
    endfunction

    // print one mismatch line and count it
    task report_mismatch(string msg);
      $display("mismatch @%0t: %s", $time, msg);
      errors++;
    endtask

    // note an accepted input transaction
    function void note_input(logic [1:0] op, logic [7:0] b);
      bit [7:0] ks;
      case (op)
        kbme_pkg::OP_KEY: begin
          if (!sched && nkey < 256) begin
            tbl[nkey] = b;
            acc = acc + b;
            nkey++;
          end
        end
        kbme_pkg::OP_DATA: begin
          if (!sched) key_schedule();
          ks = stir(tpos[7:0]);
          tag[tpos] = (tag[tpos] + b) ^ (ks ^ b);
          tpos = (tpos + 1) % TAGN;
          wpos = wpos + 8'd1;
        end
        kbme_pkg::OP_FINISH: begin
          if (!sched) key_schedule();
          wpos = 0;
          for (int x = 0; x < ROUNDS; x++) begin
            ks = stir(wpos);
            tag[x % TAGN] ^= ks;
            wpos = wpos + 8'd1;
          end
          for (int x = 0; x < TAGN; x++) pending.push_back('{tag[x], x == TAGN - 1});
          clear();
        end
        default: ;
      endcase
    endfunction

    // check one emitted tag byte
    task check_output(logic [7:0] mac, logic last);
      tag_beat_t w;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected tag byte %02h", mac));
        return;
      end
      w = pending.pop_front();
      if (mac !== w.mac)
        report_mismatch($sformatf("mac_byte got %02h want %02h", mac, w.mac));
      if (last !== w.last)
        report_mismatch($sformatf("final_byte got %b want %b", last, w.last));
    endtask
  endclass

  logic       clk = 0;
  logic       rst_n = 0;
  logic       in_valid = 0;
  logic       in_ready;
  logic [1:0] in_op = kbme_pkg::OP_KEY;
  logic [7:0] in_byte_value = 0;
  logic       out_valid;
  logic       out_ready = 0;
  logic [7:0] out_mac_byte;
  logic       out_final_byte;

  mac_scoreboard sb = new();
  bit  quiet = 0;      // no idling in the closing stretch
  bit  hold_out = 0;   // long receiver hold-off request
  int  stall_cnt = 0;

  always #4 clk = ~clk;

  keyed_byte_mac_engine dut (.*);

  // monitor: note inputs and check outputs at each edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_input(in_op, in_byte_value);
      if (out_valid && out_ready) sb.check_output(out_mac_byte, out_final_byte);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= IDLE_LIM) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver: random back-pressure bursts, plus one long hold-off that
  // outlasts the key schedule so the tag output backs up
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      if (hold_out) begin
        out_ready <= 0;
        repeat (3000) @(posedge clk);
        hold_out = 0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 13);
        out_ready <= 0;
        repeat (gap) @(posedge clk);
      end else begin
        out_ready <= 1;
        @(posedge clk);
      end
    end
  end

  // send one transaction, with an optional random gap before it
  task automatic send(logic [1:0] op, logic [7:0] b);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid      <= 1;
    in_op         <= op;
    in_byte_value <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // one message: key, data, finish
  task automatic message(int nk, int nd);
    for (int i = 0; i < nk; i++) send(kbme_pkg::OP_KEY, 8'($urandom_range(0, 255)));
    for (int i = 0; i < nd; i++) send(kbme_pkg::OP_DATA, 8'($urandom_range(0, 255)));
    send(kbme_pkg::OP_FINISH, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    int sent;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: empty message, extremes, spare op, key after schedule
    send(kbme_pkg::OP_FINISH, 8'h00);
    send(kbme_pkg::OP_KEY, 8'hff);
    send(kbme_pkg::OP_KEY, 8'h00);
    send(kbme_pkg::OP_UNUSED, 8'ha5);
    send(kbme_pkg::OP_DATA, 8'hff);
    send(kbme_pkg::OP_KEY, 8'h55);
    send(kbme_pkg::OP_DATA, 8'h00);
    send(kbme_pkg::OP_UNUSED, 8'h5a);
    send(kbme_pkg::OP_FINISH, 8'hff);
    // finish with key only, no data
    send(kbme_pkg::OP_KEY, 8'haa);
    send(kbme_pkg::OP_FINISH, 8'h00);
    drain();

    // longer key, then long receiver hold-off while the block is busy
    for (int i = 0; i < 30; i++) send(kbme_pkg::OP_KEY, 8'($urandom_range(0, 255)));
    send(kbme_pkg::OP_DATA, 8'h81);
    send(kbme_pkg::OP_FINISH, 8'h00);
    hold_out = 1;
    for (int i = 0; i < 10; i++) send(kbme_pkg::OP_DATA, 8'($urandom_range(0, 255)));
    send(kbme_pkg::OP_FINISH, 8'h00);
    drain();  // sender pauses until every tag byte has come back

    // random messages, mostly well formed with occasional noise
    sent = 54;
    while (sent < 180) begin
      int nk, nd;
      if (sent > 150) quiet = 1;
      nk = $urandom_range(0, 3) == 0 ? $urandom_range(0, 20) : $urandom_range(0, 6);
      nd = $urandom_range(0, 10);
      if ($urandom_range(0, 5) == 0) begin
        send(kbme_pkg::OP_UNUSED, 8'($urandom_range(0, 255)));
        sent++;
      end
      message(nk, nd);
      sent += nk + nd + 1;
    end
    drain();
    in_valid <= 0;
    repeat (400) @(posedge clk);

    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end
endmodule
